>>> src/tsa_pkg.sv
`default_nettype none
package tsa_pkg;

   localparam int DIV_NUM_W   = 88;
   localparam int DIV_DEN_W   = 35;
   localparam int DIV_CNT_W   = 7;
   localparam int SQRT_RAD_W  = 66;
   localparam int SQRT_ROOT_W = 35;
   localparam int SQRT_CNT_W  = 6;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_REJ = 2'd1;
   localparam logic [1:0] STAT_SAT = 2'd2;

   localparam logic [1:0] TERM_XX = 2'd0;
   localparam logic [1:0] TERM_YY = 2'd1;
   localparam logic [1:0] TERM_XY = 2'd2;

   localparam logic [2:0] CSR_ADDR_E = 3'd0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQR,
      ST_SQRT,
      ST_DIV_CX,
      ST_DIV_CY,
      ST_MUL_EA,
      ST_DIV_K,
      ST_TERM,
      ST_ACC,
      ST_READ,
      ST_DONE
   } state_type;

   // 64-bit add that clamps at the signed limits
   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      logic [64:0] r;
      s = {a[63], a} + {b[63], b};
      r = {1'b0, s[63:0]};
      if (s[64] != s[63]) begin
         r = s[64] ? {1'b1, 64'h8000_0000_0000_0000} : {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/tsa_mem.sv
`default_nettype none
module tsa_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [63:0]        rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [63:0]   wr_data
);

   logic [63:0] mem_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> src/tsa_div.sv
`default_nettype none
module tsa_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [tsa_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [tsa_pkg::DIV_DEN_W-1:0] den,
   output logic                                busy,
   output logic                                done,
   output logic [tsa_pkg::DIV_NUM_W-1:0]      quot
);

   localparam int NW = tsa_pkg::DIV_NUM_W;
   localparam int DW = tsa_pkg::DIV_DEN_W;

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff;
   logic [DW:0]   rem_ff, rem_in;
   logic [NW-1:0] quot_ff, quot_in;
   logic [tsa_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [DW:0]   rem_sh;
   logic          ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      rem_sh  = {rem_ff[DW-1:0], num_ff[NW-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_in  = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
      quot_in = {quot_ff[NW-2:0], ge};
      num_in  = {num_ff[NW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == tsa_pkg::DIV_CNT_W'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (busy_ff) begin
         num_ff  <= num_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

>>> src/tsa_sqrt.sv
`default_nettype none
module tsa_sqrt (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [tsa_pkg::SQRT_RAD_W-1:0]  rad,
   output logic                                  done,
   output logic [tsa_pkg::SQRT_ROOT_W-1:0]      root
);

   localparam int RW = tsa_pkg::SQRT_ROOT_W;
   localparam int PW = 2 * RW;

   logic [PW-1:0]   rad_ff;
   logic [RW:0]     rem_ff;
   logic [RW-1:0]   root_ff;
   logic [tsa_pkg::SQRT_CNT_W-1:0] cnt_ff;
   logic            busy_ff, done_ff;
   logic [RW+2:0]   rem_sh, trial, rem_in;
   logic            ge;

   // two radicand bits in, one root bit out per cycle
   always_comb begin
      rem_sh = {rem_ff, rad_ff[PW-1:PW-2]};
      trial  = {1'b0, root_ff, 2'b01};
      ge     = rem_sh >= trial;
      rem_in = ge ? rem_sh - trial : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == tsa_pkg::SQRT_CNT_W'(RW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= PW'(rad);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[PW-3:0], 2'b00};
         rem_ff  <= rem_in[RW:0];
         root_ff <= {root_ff[RW-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

>>> src/truss_stiffness_assembly_top.sv
// Add member: the time is set by the serial square root and the three 88-step
//   divisions on the shared divider.
// Operation three skips to the result; clear zeroes all (2*MAX_NODES)^2 words.
// One item at a time; the next is taken once the result sits in the output register.
// Reset is synchronous; after reset a clearing pass over all (2*MAX_NODES)^2 words
//   zeroes the matrix memory before the first item is taken.
`default_nettype none
module truss_stiffness_assembly_top #(
   parameter int MAX_NODES = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // first_node, second_node, first_x, first_y, second_x, second_y,
   // member_area, read_row, read_col, zero pad
   input  wire logic [183:0] req_tdata,
   // operation
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // entry_value, member_length, term_xx, term_yy, term_xy
   output logic [287:0]      rsp_tdata,
   // status
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int DOFS  = 2 * MAX_NODES;
   localparam int DEPTH = DOFS * DOFS;
   localparam int AW    = $clog2(DEPTH);

   tsa_pkg::state_type state_ff, state_in;

   logic [31:0]  emod_ff;
   logic [1:0]   op_ff;
   logic [4:0]   ni_ff, nj_ff;
   logic [5:0]   row_ff, col_ff;
   logic [31:0]  area_ff;
   logic [32:0]  ux_ff, uy_ff;
   logic         negxy_ff;
   logic [65:0]  sumsq_ff;
   logic [34:0]  len_ff;
   logic [30:0]  cx_ff, cy_ff;
   logic [62:0]  k_ff;
   logic [60:0]  p_ff;
   logic [123:0] acc_ff;
   logic [63:0]  term_ff [0:2];
   logic [2:0]   step_ff;
   logic [1:0]   tsel_ff;
   logic [4:0]   idx_ff;
   logic [AW-1:0] clr_ff;
   logic         clr_rsp_ff;
   logic         rej_ff, sat_ff;
   logic         rdok_ff;
   logic [63:0]  entry_ff;
   logic         pend_ff;
   logic [AW-1:0] pend_addr_ff;
   logic [63:0]  pend_elem_ff;
   logic [65:0]  prod_ff;
   logic         out_valid_ff;
   logic [287:0] out_data_ff;
   logic [1:0]   out_user_ff;

   logic [32:0]  mul_a, mul_b;
   logic         sq_start, sq_done;
   logic [34:0]  sq_root;
   logic         div_start, div_done, div_busy;
   logic [87:0]  div_num, div_quot;
   logic         mem_rd_en, mem_wr_en;
   logic [AW-1:0] mem_rd_addr, mem_wr_addr;
   logic [63:0]  mem_rd_data, mem_wr_data;
   logic [64:0]  acc_sum;
   logic         rej_now;
   logic         acc_last, out_free;
   logic [AW-1:0] acc_addr, rd_addr;
   logic [63:0]  acc_elem;
   logic [5:0]   dof_r, dof_c;
   logic [63:0]  base_elem;
   logic [31:0]  fx, fy, sx, sy;
   logic [32:0]  dx, dy;
   logic         rd_inrange;
   logic [63:0]  term_mag;
   logic [30:0]  c1, c2;

   // request fields
   assign fx = req_tdata[41:10];
   assign fy = req_tdata[73:42];
   assign sx = req_tdata[105:74];
   assign sy = req_tdata[137:106];
   assign dx = {sx[31], sx} - {fx[31], fx};
   assign dy = {sy[31], sy} - {fy[31], fy};

   assign rej_now = (ni_ff == nj_ff) || (sq_root == '0) ||
                    (32'(ni_ff) >= MAX_NODES) || (32'(nj_ff) >= MAX_NODES);
   assign acc_last = idx_ff == 5'd16;
   assign out_free = !out_valid_ff || rsp_tready;
   assign rd_inrange = (32'(row_ff) < DOFS) && (32'(col_ff) < DOFS);
   assign rd_addr = AW'(AW'(row_ff) * AW'(DOFS) + AW'(col_ff));

   // element of the 4x4 member matrix for position idx
   always_comb begin
      dof_r = {(idx_ff[3] ? nj_ff : ni_ff), idx_ff[2]};
      dof_c = {(idx_ff[1] ? nj_ff : ni_ff), idx_ff[0]};
      acc_addr = AW'(AW'(dof_r) * AW'(DOFS) + AW'(dof_c));
      unique case ({idx_ff[2], idx_ff[0]})
         2'b00:   base_elem = term_ff[0];
         2'b11:   base_elem = term_ff[1];
         default: base_elem = term_ff[2];
      endcase
      acc_elem = (idx_ff[3] != idx_ff[1]) ? -base_elem : base_elem;
   end

   assign acc_sum = tsa_pkg::sat_add(mem_rd_data, pend_elem_ff);

   always_comb begin
      unique case (tsel_ff)
         tsa_pkg::TERM_XX: begin c1 = cx_ff; c2 = cx_ff; end
         tsa_pkg::TERM_YY: begin c1 = cy_ff; c2 = cy_ff; end
         default:          begin c1 = cx_ff; c2 = cy_ff; end
      endcase
   end
   assign term_mag = acc_ff[123:60];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsa_pkg::ST_CLEAR:
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = clr_rsp_ff ? tsa_pkg::ST_DONE : tsa_pkg::ST_IDLE;
            end
         tsa_pkg::ST_IDLE:
            if (req_tvalid) begin
               unique case (req_tuser)
                  tsa_pkg::OP_ADD:   state_in = tsa_pkg::ST_SQR;
                  tsa_pkg::OP_READ:  state_in = tsa_pkg::ST_READ;
                  tsa_pkg::OP_CLEAR: state_in = tsa_pkg::ST_CLEAR;
                  default:           state_in = tsa_pkg::ST_DONE;
               endcase
            end
         tsa_pkg::ST_SQR:    if (step_ff == 3'd2) state_in = tsa_pkg::ST_SQRT;
         tsa_pkg::ST_SQRT:
            if (sq_done) begin
               state_in = rej_now ? tsa_pkg::ST_DONE : tsa_pkg::ST_DIV_CX;
            end
         tsa_pkg::ST_DIV_CX: if (div_done) state_in = tsa_pkg::ST_DIV_CY;
         tsa_pkg::ST_DIV_CY: if (div_done) state_in = tsa_pkg::ST_MUL_EA;
         tsa_pkg::ST_MUL_EA: if (step_ff == 3'd1) state_in = tsa_pkg::ST_DIV_K;
         tsa_pkg::ST_DIV_K:  if (div_done) state_in = tsa_pkg::ST_TERM;
         tsa_pkg::ST_TERM:
            if (step_ff == 3'd7 && tsel_ff == tsa_pkg::TERM_XY) state_in = tsa_pkg::ST_ACC;
         tsa_pkg::ST_ACC:    if (acc_last) state_in = tsa_pkg::ST_DONE;
         tsa_pkg::ST_READ:   if (step_ff == 3'd1) state_in = tsa_pkg::ST_DONE;
         tsa_pkg::ST_DONE:   if (out_free) state_in = tsa_pkg::ST_IDLE;
         default:            state_in = tsa_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = state_ff == tsa_pkg::ST_IDLE;
      mul_a       = '0;
      mul_b       = '0;
      sq_start    = state_ff == tsa_pkg::ST_SQR && step_ff == 3'd2;
      div_start   = 1'b0;
      div_num     = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = acc_addr;
      mem_wr_en   = 1'b0;
      mem_wr_addr = pend_addr_ff;
      mem_wr_data = acc_sum[63:0];
      unique case (state_ff)
         tsa_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
         end
         tsa_pkg::ST_SQR: begin
            mul_a = (step_ff == 3'd0) ? ux_ff : uy_ff;
            mul_b = mul_a;
         end
         tsa_pkg::ST_SQRT: begin
            div_start = sq_done && !rej_now;
            div_num   = {25'd0, sq_done ? 33'(ux_ff) : 33'd0, 30'd0};
         end
         tsa_pkg::ST_DIV_CX: begin
            div_start = div_done;
            div_num   = {25'd0, uy_ff, 30'd0};
         end
         tsa_pkg::ST_MUL_EA: begin
            mul_a     = {1'b0, emod_ff};
            mul_b     = {1'b0, area_ff};
            div_start = step_ff == 3'd1;
            div_num   = {prod_ff[63:0], 24'd0};
         end
         tsa_pkg::ST_TERM: begin
            unique case (step_ff)
               3'd0: begin mul_a = 33'(c1); mul_b = 33'(c2); end
               3'd2: begin mul_a = 33'(k_ff[31:0]); mul_b = 33'(p_ff[31:0]); end
               3'd3: begin mul_a = 33'(k_ff[31:0]); mul_b = 33'(p_ff[60:32]); end
               3'd4: begin mul_a = 33'(k_ff[62:32]); mul_b = 33'(p_ff[31:0]); end
               3'd5: begin mul_a = 33'(k_ff[62:32]); mul_b = 33'(p_ff[60:32]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         tsa_pkg::ST_ACC: begin
            mem_rd_en = !acc_last;
            mem_wr_en = pend_ff;
         end
         tsa_pkg::ST_READ: begin
            mem_rd_en   = step_ff == 3'd0 && rd_inrange;
            mem_rd_addr = rd_addr;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsa_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         step_ff      <= '0;
         tsel_ff      <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         emod_ff      <= 32'd1;
      end else begin
         state_ff <= state_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == tsa_pkg::CSR_ADDR_E) begin
            emod_ff <= csr_pwdata;
         end
         if (state_ff == tsa_pkg::ST_DONE && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         // the step count wraps from 7 to 0 between terms
         if (state_in != state_ff) begin
            step_ff <= '0;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
         unique case (state_ff)
            tsa_pkg::ST_CLEAR: clr_ff <= clr_ff + 1'b1;
            tsa_pkg::ST_IDLE: begin
               clr_ff     <= '0;
               clr_rsp_ff <= 1'b1;
               tsel_ff    <= '0;
               idx_ff     <= '0;
               pend_ff    <= 1'b0;
            end
            tsa_pkg::ST_TERM:
               if (step_ff == 3'd7) begin
                  tsel_ff <= tsel_ff + 1'b1;
               end
            tsa_pkg::ST_ACC: begin
               pend_ff <= !acc_last;
               if (!acc_last) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         tsa_pkg::ST_IDLE:
            if (req_tvalid) begin
               op_ff    <= req_tuser;
               ni_ff    <= req_tdata[4:0];
               nj_ff    <= req_tdata[9:5];
               area_ff  <= req_tdata[169:138];
               row_ff   <= req_tdata[175:170];
               col_ff   <= req_tdata[181:176];
               ux_ff    <= dx[32] ? -dx : dx;
               uy_ff    <= dy[32] ? -dy : dy;
               negxy_ff <= (dx != '0) && (dy != '0) && (dx[32] != dy[32]);
               len_ff   <= '0;
               rej_ff   <= 1'b0;
               sat_ff   <= 1'b0;
               entry_ff <= '0;
            end
         tsa_pkg::ST_SQR:
            if (step_ff == 3'd1) begin
               sumsq_ff <= prod_ff;
            end else if (step_ff == 3'd2) begin
               sumsq_ff <= sumsq_ff + prod_ff;
            end
         tsa_pkg::ST_SQRT:
            if (sq_done) begin
               len_ff <= sq_root;
               rej_ff <= rej_now;
            end
         tsa_pkg::ST_DIV_CX: if (div_done) cx_ff <= div_quot[30:0];
         tsa_pkg::ST_DIV_CY: if (div_done) cy_ff <= div_quot[30:0];
         tsa_pkg::ST_DIV_K:
            if (div_done) begin
               if (div_quot[87:63] != '0) begin
                  k_ff   <= '1;
                  sat_ff <= 1'b1;
               end else begin
                  k_ff <= div_quot[62:0];
               end
            end
         tsa_pkg::ST_TERM:
            unique case (step_ff)
               3'd1: p_ff <= prod_ff[60:0];
               3'd3: acc_ff <= 124'(prod_ff);
               3'd4: acc_ff <= acc_ff + (124'(prod_ff) << 32);
               3'd5: acc_ff <= acc_ff + (124'(prod_ff) << 32);
               3'd6: acc_ff <= acc_ff + (124'(prod_ff) << 64);
               3'd7: begin
                  if (tsel_ff == tsa_pkg::TERM_XY) begin
                     term_ff[2] <= negxy_ff ? -term_mag : term_mag;
                  end else if (tsel_ff == tsa_pkg::TERM_YY) begin
                     term_ff[1] <= term_mag;
                  end else begin
                     term_ff[0] <= term_mag;
                  end
               end
               default: ;
            endcase
         tsa_pkg::ST_ACC: begin
            pend_addr_ff <= acc_addr;
            pend_elem_ff <= acc_elem;
            if (pend_ff && acc_sum[64]) begin
               sat_ff <= 1'b1;
            end
         end
         tsa_pkg::ST_READ:
            if (step_ff == 3'd0) begin
               rdok_ff <= rd_inrange;
            end else begin
               entry_ff <= rdok_ff ? mem_rd_data : '0;
            end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == tsa_pkg::ST_DONE && out_free) begin
         out_data_ff <= '0;
         out_user_ff <= tsa_pkg::STAT_OK;
         if (op_ff == tsa_pkg::OP_READ) begin
            out_data_ff[63:0] <= entry_ff;
         end
         if (op_ff == tsa_pkg::OP_ADD) begin
            out_data_ff[95:64] <= (len_ff[34:32] != '0) ? 32'hFFFF_FFFF : len_ff[31:0];
            if (rej_ff) begin
               out_user_ff <= tsa_pkg::STAT_REJ;
            end else begin
               out_data_ff[159:96]  <= term_ff[0];
               out_data_ff[223:160] <= term_ff[1];
               out_data_ff[287:224] <= term_ff[2];
               out_user_ff <= sat_ff ? tsa_pkg::STAT_SAT : tsa_pkg::STAT_OK;
            end
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == tsa_pkg::CSR_ADDR_E) ? emod_ff : 32'd0;

   tsa_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .rad   (sq_start ? sumsq_ff + prod_ff : sumsq_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   tsa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   ((state_ff == tsa_pkg::ST_SQRT) ? sq_root : len_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   tsa_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_acc_not_rejected: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsa_pkg::ST_ACC || state_ff == tsa_pkg::ST_TERM) |-> !rej_ff)
      else $error("rejected member reached accumulation");

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsa_pkg::ST_CLEAR) |-> (mem_wr_en && mem_wr_data == '0))
      else $error("clearing pass wrote nonzero data");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsa_pkg::ST_DONE && !out_valid_ff) |=> out_valid_ff)
      else $error("result not loaded from DONE");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = 32;
   localparam int DOFS  = 2 * NODES;

   typedef struct packed {
      logic [1:0]  op;
      logic [4:0]  node_a;
      logic [4:0]  node_b;
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] bx;
      logic [31:0] by;
      logic [31:0] area;
      logic [5:0]  row;
      logic [5:0]  col;
   } member_req_type;

   typedef struct packed {
      logic [63:0] entry;
      logic [31:0] length;
      logic [63:0] kxx;
      logic [63:0] kyy;
      logic [63:0] kxy;
      logic [1:0]  status;
   } member_rsp_type;

   class stiffness_scoreboard;
      logic [31:0]        modulus;
      logic signed [63:0] stiff [DOFS*DOFS];
      member_rsp_type     awaited[$];
      int                 mismatches;

      function new();
         modulus = 1;
         mismatches = 0;
         foreach (stiff[i]) stiff[i] = 0;
      endfunction

      function logic [127:0] root_of(logic [127:0] v);
         logic [127:0] r;
         logic [127:0] t;
         r = 0;
         for (int b = 34; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function logic [63:0] scale(logic [63:0] k, logic [63:0] c1, logic [63:0] c2);
         logic [63:0]  prod;
         logic [127:0] p;
         prod = c1 * c2;
         p = {64'd0, k} * {64'd0, prod};
         return p[123:60];
      endfunction

      // accumulate with clamping at the signed limits
      function void accumulate(int idx, logic signed [63:0] v, inout bit sat);
         logic signed [64:0] s;
         s = {stiff[idx][63], stiff[idx]} + {v[63], v};
         if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
            stiff[idx] = 64'h7FFF_FFFF_FFFF_FFFF;
            sat = 1;
         end else if (s < -65'sh0_8000_0000_0000_0000) begin
            stiff[idx] = 64'h8000_0000_0000_0000;
            sat = 1;
         end else begin
            stiff[idx] = s[63:0];
         end
      endfunction

      function void note_request(member_req_type q);
         member_rsp_type     e;
         logic signed [63:0] dx, dy, t[3], m[4][4];
         logic [63:0]        ux, uy, len, cx, cy, k;
         logic [127:0]       n, quo;
         int                 dof[4];
         bit                 sat;
         e = '{default: '0};
         e.status = tsa_pkg::STAT_OK;
         if (q.op == tsa_pkg::OP_READ) begin
            e.entry = stiff[q.row * DOFS + q.col];
         end else if (q.op == tsa_pkg::OP_CLEAR) begin
            foreach (stiff[i]) stiff[i] = 0;
         end else if (q.op == tsa_pkg::OP_ADD) begin
            dx = $signed(q.bx) - $signed(q.ax);
            dy = $signed(q.by) - $signed(q.ay);
            ux = dx < 0 ? -dx : dx;
            uy = dy < 0 ? -dy : dy;
            len = root_of({64'd0, ux} * ux + {64'd0, uy} * uy);
            e.length = len > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : len[31:0];
            if (q.node_a == q.node_b || len == 0) begin
               e.status = tsa_pkg::STAT_REJ;
            end else begin
               sat = 0;
               cx = (ux << 30) / len;
               cy = (uy << 30) / len;
               n = ({96'd0, modulus} * {96'd0, q.area}) << 24;
               quo = n / {64'd0, len};
               if (quo > 128'h7FFF_FFFF_FFFF_FFFF) begin
                  k = 64'h7FFF_FFFF_FFFF_FFFF;
                  sat = 1;
               end else begin
                  k = quo[63:0];
               end
               t[0] = scale(k, cx, cx);
               t[1] = scale(k, cy, cy);
               t[2] = scale(k, cx, cy);
               if ((dx < 0 && dy > 0) || (dx > 0 && dy < 0)) t[2] = -t[2];
               m[0] = '{t[0], t[2], -t[0], -t[2]};
               m[1] = '{t[2], t[1], -t[2], -t[1]};
               m[2] = '{-t[0], -t[2], t[0], t[2]};
               m[3] = '{-t[2], -t[1], t[2], t[1]};
               dof = '{2*q.node_a, 2*q.node_a+1, 2*q.node_b, 2*q.node_b+1};
               for (int r = 0; r < 4; r++)
                  for (int c = 0; c < 4; c++)
                     accumulate(dof[r] * DOFS + dof[c], m[r][c], sat);
               e.kxx = t[0];
               e.kyy = t[1];
               e.kxy = t[2];
               e.status = sat ? tsa_pkg::STAT_SAT : tsa_pkg::STAT_OK;
            end
         end
         awaited.push_back(e);
      endfunction

      function void check_response(member_rsp_type got);
         member_rsp_type e;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer on rsp: %p", got);
            return;
         end
         e = awaited.pop_front();
         if (got != e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch at %0t\n  expected %p\n  actual   %p", $realtime, e, got);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [183:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [287:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel = 0;
   logic         csr_penable = 0;
   logic         csr_pwrite = 0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   stiffness_scoreboard sb = new();
   bit  calm = 0;
   bit  long_hold = 0;
   int  touched[$];

   always #5 clock = ~clock;

   truss_stiffness_assembly_top #(.MAX_NODES(NODES)) dut (.*);

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request('{req_tuser, req_tdata[4:0], req_tdata[9:5], req_tdata[41:10],
                           req_tdata[73:42], req_tdata[105:74], req_tdata[137:106],
                           req_tdata[169:138], req_tdata[175:170], req_tdata[181:176]});
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response('{rsp_tdata[63:0], rsp_tdata[95:64], rsp_tdata[159:96],
                             rsp_tdata[223:160], rsp_tdata[287:224], rsp_tuser});
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (3000) @(negedge clock);
            long_hold = 0;
            rsp_tready <= 1;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(0, 18);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   initial begin
      #30_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic csr_write(logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= tsa_pkg::CSR_ADDR_E;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      sb.modulus = value;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // called at a falling edge; returns at a falling edge after the transfer
   task automatic send(member_req_type q);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= q.op;
      req_tdata <= {2'b00, q.col, q.row, q.area, q.by, q.bx, q.ay, q.ax, q.node_b, q.node_a};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic member_req_type add_member(int na, int nb, logic [31:0] ax,
                                                 logic [31:0] ay, logic [31:0] bx,
                                                 logic [31:0] by, logic [31:0] area);
      member_req_type q;
      q = '{tsa_pkg::OP_ADD, 5'(na), 5'(nb), ax, ay, bx, by, area,
            6'($urandom), 6'($urandom)};
      return q;
   endfunction

   function automatic member_req_type read_entry(int r, int c);
      member_req_type q;
      q = '{tsa_pkg::OP_READ, 5'($urandom), 5'($urandom), $urandom, $urandom, $urandom,
            $urandom, $urandom, 6'(r), 6'(c)};
      return q;
   endfunction

   function automatic member_req_type random_item();
      member_req_type q;
      int             sel, na, nb;
      logic [31:0]    ax, ay, span;
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
         q = read_entry(0, 0);
         q.op = tsa_pkg::OP_CLEAR;
      end else if (sel < 33) begin
         if (touched.size() > 0 && $urandom_range(0, 3) != 0)
            q = read_entry(2 * touched[$urandom_range(0, touched.size() - 1)]
                           + $urandom_range(0, 1),
                           2 * touched[$urandom_range(0, touched.size() - 1)]
                           + $urandom_range(0, 1));
         else
            q = read_entry($urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
         na = $urandom_range(0, 31);
         nb = $urandom_range(0, 31);
         if ($urandom_range(0, 19) == 0) nb = na;
         ax = $urandom;
         ay = $urandom;
         span = 32'd1 << $urandom_range(4, 31);
         q = add_member(na, nb, ax, ay,
                        ax + $urandom_range(0, span) - span / 2,
                        ay + $urandom_range(0, span) - span / 2,
                        $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000));
         case ($urandom_range(0, 9))
            0: begin q.bx = q.ax; q.by = q.ay; end
            1: begin q.bx = $urandom; q.by = $urandom; end
            2: q.bx = q.ax;
            3: q.by = q.ay;
            default: ;
         endcase
         touched.push_back(na);
         touched.push_back(nb);
         if (touched.size() > 8) void'(touched.pop_front());
      end
      return q;
   endfunction

   initial begin
      logic [31:0] moduli[4];
      moduli = '{32'd0, 32'hFFFF_FFFF, 32'd70000, $urandom};
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed part with the default modulus
      send(add_member(0, 31, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'hFFFF_FFFF));
      send(add_member(1, 2, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0006_0000,
                      32'h0001_0000));
      send(add_member(3, 4, 32'h0005_0000, 32'h0000_0000, 32'h0001_0000, 32'h0003_0000,
                      32'h0002_0000));
      send(add_member(5, 5, 32'h0001_0000, 32'h0001_0000, 32'h0009_0000, 32'h0001_0000,
                      32'h0001_0000));
      send(add_member(6, 7, 32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321,
                      32'h0001_0000));
      send(add_member(8, 9, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0003_0000, 32'd0));
      send(add_member(9, 10, 32'h0000_0000, 32'h0000_0000, 32'hFFFD_0000, 32'h0000_0000,
                      32'h0001_0000));
      send(read_entry(0, 0));
      send(read_entry(63, 63));
      send(read_entry(2, 5));
      send(read_entry(7, 4));
      drain();
      csr_write(32'hFFFF_FFFF);
      // tiny members with huge stiffness clamp k and then the accumulations
      repeat (3) send(add_member(11, 12, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send(read_entry(22, 22));
      send(read_entry(22, 25));
      send(read_entry(24, 23));
      send(add_member(13, 14, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0));
      send(read_entry(0, 0));
      send(add_member(0, 1, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
                      32'h0001_0000));
      send(read_entry(62, 63));
      send(read_entry(0, 0));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(moduli[ph]);
         for (int i = 0; i < 345; i++) begin
            if (ph == 1 && i == 100) long_hold = 1;
            if (ph == 3 && i == 200) calm = 1;
            send(random_item());
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
